### hdl/two_class_priority_queue_cancel_assert.svh
// assertion macros for the two-class priority queue
// used by the top level only, no other dependencies
`ifndef TWO_CLASS_PRIORITY_QUEUE_CANCEL_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_CANCEL_ASSERT_SVH

// same-cycle implication
`define TCPQ_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tcpq assertion failed");

// next-cycle implication
`define TCPQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tcpq assertion failed");

`endif

### hdl/tcpq_pkg.sv
// shared types and constants for the two-class priority queue
// no dependencies
`default_nettype none
package tcpq_pkg;

   localparam int QueueDepth = 32;
   localparam int MaxBatch = 8;
   localparam logic [3:0] BatchReset = 4'd4;
   localparam int KeyWidth = 32;

   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_CALL = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      ST_REGISTERED = 3'd0,
      ST_FULL = 3'd1,
      ST_REMOVED = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_SERVED = 3'd4,
      ST_EMPTY = 3'd5
   } status_type;

   typedef struct packed {
      logic [KeyWidth-1:0] key;
      logic cls;
   } entry_type;

   typedef struct packed {
      status_type status;
      logic [KeyWidth-1:0] served_key;
      logic served_class;
      logic [5:0] remaining;
      logic last;
   } result_type;

endpackage
`default_nettype wire

### hdl/tcpq_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module tcpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input wire logic clock,
   input wire logic we,
   input wire logic [$clog2(DEPTH)-1:0] waddr,
   input wire logic [WIDTH-1:0] wdata,
   input wire logic re,
   input wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### hdl/tcpq_ctrl.sv
// queue sequencer: circular entry store in ram, insert, search, delete, batch dequeue
// depends on tcpq_pkg and tcpq_ram
`default_nettype none
module tcpq_ctrl #(
   parameter int QUEUE_DEPTH = 32
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_op,
   input wire logic [31:0] req_key,
   input wire logic req_ticket_class,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output tcpq_pkg::result_type result,
   input wire logic [3:0] batch_size
);
   import tcpq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_INS_RD, S_INS_WR, S_SRCH_RD, S_SRCH_CMP,
      S_DEL_RD, S_DEL_WR, S_CALL_RD, S_CALL_OUT, S_RESP
   } state_type;

   state_type state_ff;
   logic [CW-1:0] occ_ff, nfast_ff, idx_ff;
   logic [AW-1:0] head_ff;
   logic [3:0] cnt_ff;
   logic [KeyWidth-1:0] key_ff;
   logic cls_ff;
   status_type status_ff;
   logic rsp_valid_ff;
   result_type res_ff;

   logic ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   entry_type ram_wdata, ram_rdata;
   logic out_free;
   logic [3:0] bsz, batch_n;
   logic [AW-1:0] head_inc;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] i);
      logic [AW+1:0] s;
      s = (AW+2)'(head) + (AW+2)'(i);
      if (s >= (AW+2)'(QUEUE_DEPTH)) begin
         s = s - (AW+2)'(QUEUE_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   tcpq_ram #(.WIDTH($bits(entry_type)), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign head_inc = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   always_comb begin
      bsz = batch_size;
      if (bsz == 4'd0) begin
         bsz = 4'd1;
      end else if (bsz > 4'(MaxBatch)) begin
         bsz = 4'(MaxBatch);
      end
      batch_n = bsz;
      if ((CW+4)'(occ_ff) < (CW+4)'(bsz)) begin
         batch_n = 4'(occ_ff);
      end
   end

   always_comb begin
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_waddr = '0;
      ram_raddr = '0;
      ram_wdata = '{key: key_ff, cls: cls_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_op == OP_REGISTER && req_ticket_class
                && occ_ff != CW'(QUEUE_DEPTH)) begin
               ram_we = 1'b1;
               ram_waddr = phys(head_ff, occ_ff);
               ram_wdata = '{key: req_key, cls: 1'b1};
            end
         end
         S_INS_RD: begin
            if (idx_ff == nfast_ff) begin
               ram_we = 1'b1;
               ram_waddr = phys(head_ff, idx_ff);
            end else begin
               ram_re = 1'b1;
               ram_raddr = phys(head_ff, idx_ff - 1'b1);
            end
         end
         S_INS_WR, S_DEL_WR: begin
            ram_we = 1'b1;
            ram_waddr = phys(head_ff, idx_ff);
            ram_wdata = ram_rdata;
         end
         S_SRCH_RD: begin
            ram_re = 1'b1;
            ram_raddr = phys(head_ff, idx_ff);
         end
         S_DEL_RD: begin
            if (idx_ff + 1'b1 != occ_ff) begin
               ram_re = 1'b1;
               ram_raddr = phys(head_ff, idx_ff + 1'b1);
            end
         end
         S_CALL_RD: begin
            ram_re = 1'b1;
            ram_raddr = head_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff <= '0;
         nfast_ff <= '0;
         head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  key_ff <= req_key;
                  cls_ff <= req_ticket_class;
                  unique case (req_op)
                     OP_REGISTER: begin
                        if (occ_ff == CW'(QUEUE_DEPTH)) begin
                           status_ff <= ST_FULL;
                           state_ff <= S_RESP;
                        end else if (req_ticket_class) begin
                           occ_ff <= occ_ff + 1'b1;
                           status_ff <= ST_REGISTERED;
                           state_ff <= S_RESP;
                        end else begin
                           idx_ff <= occ_ff;
                           state_ff <= S_INS_RD;
                        end
                     end
                     OP_REMOVE: begin
                        if (occ_ff == '0) begin
                           status_ff <= ST_NOT_FOUND;
                           state_ff <= S_RESP;
                        end else begin
                           idx_ff <= '0;
                           state_ff <= S_SRCH_RD;
                        end
                     end
                     OP_CALL: begin
                        if (occ_ff == '0) begin
                           status_ff <= ST_EMPTY;
                           state_ff <= S_RESP;
                        end else begin
                           cnt_ff <= batch_n;
                           state_ff <= S_CALL_RD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_INS_RD: begin
               if (idx_ff == nfast_ff) begin
                  occ_ff <= occ_ff + 1'b1;
                  nfast_ff <= nfast_ff + 1'b1;
                  status_ff <= ST_REGISTERED;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_INS_WR;
               end
            end
            S_INS_WR: begin
               idx_ff <= idx_ff - 1'b1;
               state_ff <= S_INS_RD;
            end
            S_SRCH_RD: begin
               state_ff <= S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
               if (ram_rdata.key == key_ff) begin
                  cls_ff <= ram_rdata.cls;
                  state_ff <= S_DEL_RD;
               end else if (idx_ff + 1'b1 == occ_ff) begin
                  status_ff <= ST_NOT_FOUND;
                  state_ff <= S_RESP;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_SRCH_RD;
               end
            end
            S_DEL_RD: begin
               if (idx_ff + 1'b1 == occ_ff) begin
                  occ_ff <= occ_ff - 1'b1;
                  if (!cls_ff) begin
                     nfast_ff <= nfast_ff - 1'b1;
                  end
                  status_ff <= ST_REMOVED;
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_DEL_WR;
               end
            end
            S_DEL_WR: begin
               idx_ff <= idx_ff + 1'b1;
               state_ff <= S_DEL_RD;
            end
            S_CALL_RD: begin
               state_ff <= S_CALL_OUT;
            end
            S_CALL_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  res_ff <= '{status: ST_SERVED, served_key: ram_rdata.key,
                              served_class: ram_rdata.cls,
                              remaining: 6'(occ_ff - 1'b1),
                              last: (cnt_ff == 4'd1)};
                  head_ff <= head_inc;
                  occ_ff <= occ_ff - 1'b1;
                  if (!ram_rdata.cls) begin
                     nfast_ff <= nfast_ff - 1'b1;
                  end
                  cnt_ff <= cnt_ff - 1'b1;
                  state_ff <= (cnt_ff == 4'd1) ? S_IDLE : S_CALL_RD;
               end
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  res_ff <= '{status: status_ff, served_key: '0, served_class: 1'b0,
                              remaining: 6'(occ_ff), last: 1'b1};
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

### hdl/two_class_priority_queue_cancel.sv
// Two-class priority queue with cancel by key. Entries sit in one ring-addressed
// ram in queue order (fast class first, arrival order within a class). A regular
// register, a register on a full queue, a remove or a call on an empty queue go
// straight to the response; a fast register moves each regular entry it passes up
// by one slot; a remove reads and compares entries from the head until it hits or
// runs out, then shifts each entry behind the match down by one; a call reads and
// serves the head entry once per entry of the batch. Each shift step is one ram
// read followed by a write. The result register lets a new transaction be taken
// while the last result is still stalled; a result that finds it still occupied
// waits, adding those stall cycles.
// depends on tcpq_pkg, tcpq_ctrl and two_class_priority_queue_cancel_assert.svh
`default_nettype none
`include "two_class_priority_queue_cancel_assert.svh"
module two_class_priority_queue_cancel #(
   parameter int QUEUE_DEPTH = tcpq_pkg::QueueDepth
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_op,
   input wire logic [31:0] req_key,
   input wire logic req_ticket_class,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [31:0] rsp_served_key,
   output logic rsp_served_class,
   output logic [5:0] rsp_remaining,
   output logic rsp_last,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [3:0] csr_batch_size
);
   import tcpq_pkg::*;

   logic [3:0] batch_ff;
   result_type result;
   logic rsp_unserved;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= BatchReset;
      end else if (csr_valid && csr_ready) begin
         batch_ff <= csr_batch_size;
      end
   end

   tcpq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_key(req_key),
      .req_ticket_class(req_ticket_class),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .result(result),
      .batch_size(batch_ff)
   );

   assign rsp_status = result.status;
   assign rsp_served_key = result.served_key;
   assign rsp_served_class = result.served_class;
   assign rsp_remaining = result.remaining;
   assign rsp_last = result.last;

   assign rsp_unserved = rsp_valid && rsp_status != ST_SERVED;

   `TCPQ_ASSERT_IMPLY(a_single_is_last, rsp_unserved, rsp_last)
   `TCPQ_ASSERT_IMPLY(a_unserved_zero, rsp_unserved, rsp_served_key == '0 && !rsp_served_class)
   `TCPQ_ASSERT_IMPLY(a_empty_remaining, rsp_valid && rsp_status == ST_EMPTY, rsp_remaining == '0)
   `TCPQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall && req_op != OP_UNUSED, req_stall)

endmodule
`default_nettype wire
